// ===== rtl/core/cfb_pkg.sv =====
// cfb_pkg: shared types, constants and command codes of the clipped fill and blit engine
// depends on nothing
`timescale 1ns / 1ps
package cfb_pkg;
	localparam int MaxWidth  = 512;
	localparam int MaxHeight = 256;
	localparam int XW = $clog2(MaxWidth + 1);
	localparam int YW = $clog2(MaxHeight + 1);
	localparam int AW = $clog2(MaxWidth * MaxHeight);
	localparam int CW = 14;
	localparam int PW = 32;
	localparam int IW = 3;
	// internal signed coordinate width, enough for sums of 14-bit values
	localparam int SW = 17;

	typedef enum logic [2:0] {
		OP_FILL  = 3'd0,
		OP_PIXEL = 3'd1,
		OP_FRAME = 3'd2,
		OP_BLIT  = 3'd3,
		OP_SRC   = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		REG_SURF_W = 3'd0,
		REG_SURF_H = 3'd1,
		REG_CLIP_L = 3'd2,
		REG_CLIP_T = 3'd3,
		REG_SPAN_X = 3'd4,
		REG_SPAN_Y = 3'd5
	} reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_READ,
		ST_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_rect;   // latch a rectangle span for the fill walker
		logic step;        // write current fill pixel and advance
		logic clear_step;  // clear sweep write
		logic read_issue;  // launch store read
		logic read_take;   // capture read data into output register
		logic [1:0] edge_sel;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;        // fill walker is at its final pixel (or span empty)
		logic clear_done;
	} ctl_sts_t;
endpackage

// ===== rtl/core/cfb_if.sv =====
// cfb_if: valid/ready channel interfaces for commands, results and configuration
// depends on cfb_pkg
`timescale 1ns / 1ps
interface cfb_cmd_if;
	import cfb_pkg::*;
	logic valid;
	logic ready;
	logic [2:0] opcode;
	logic signed [13:0] pos_x;
	logic signed [13:0] pos_y;
	logic signed [13:0] rect_w;
	logic signed [13:0] rect_h;
	logic [13:0] src_stride;
	logic [31:0] color;
	modport source(output valid, opcode, pos_x, pos_y, rect_w, rect_h, src_stride, color,
		input ready);
	modport sink(input valid, opcode, pos_x, pos_y, rect_w, rect_h, src_stride, color,
		output ready);
endinterface

interface cfb_res_if;
	logic valid;
	logic ready;
	logic [31:0] pixel_value;
	logic inside_surface;
	modport source(output valid, pixel_value, inside_surface, input ready);
	modport sink(input valid, pixel_value, inside_surface, output ready);
endinterface

interface cfb_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [9:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/cfb_ram.sv =====
// cfb_ram: generic ram with one write port and one registered read port
// depends on nothing
`timescale 1ns / 1ps
module cfb_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/cfb_ctrl.sv =====
// cfb_ctrl: command sequencer state machine
// depends on cfb_pkg
`timescale 1ns / 1ps
module cfb_ctrl import cfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_fire,
	input  logic [2:0] cmd_op,
	input  logic frame_ok,
	input  logic res_busy,
	input  logic res_taken,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd,
	output logic busy,
	output logic res_valid
);
	state_t state_q, state_nx;
	logic [1:0] edge_q, edge_nx;
	logic frame_q, frame_nx;

	always_comb begin
		state_nx = state_q;
		edge_nx = edge_q;
		frame_nx = frame_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clear_done) state_nx = ST_IDLE;
			ST_IDLE: begin
				if (cmd_fire && (cmd_op == OP_FILL || (cmd_op == OP_FRAME && frame_ok))) begin
					state_nx = ST_FILL;
					edge_nx = 2'd0;
					frame_nx = (cmd_op == OP_FRAME);
				end else if (cmd_fire && cmd_op == OP_READ) begin
					state_nx = ST_READ;
				end
			end
			ST_FILL: begin
				if (sts.last) begin
					if (frame_q && edge_q != 2'd3) edge_nx = edge_q + 2'd1;
					else state_nx = ST_IDLE;
				end
			end
			ST_READ: state_nx = ST_RESULT;
			ST_RESULT: if (res_taken) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.edge_sel = edge_q;
		busy = 1'b1;
		res_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clear_step = 1'b1;
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load_rect = 1'b1;
				cmd.edge_sel = 2'd0;
				cmd.read_issue = 1'b1;
			end
			ST_FILL: begin
				cmd.step = 1'b1;
				// reload next edge once the current one finishes
				cmd.load_rect = sts.last && frame_q && edge_q != 2'd3;
				cmd.edge_sel = sts.last ? edge_q + 2'd1 : edge_q;
			end
			ST_READ: cmd.read_take = 1'b1;
			ST_RESULT: res_valid = 1'b1;
			default: ;
		endcase
		if (res_busy) busy = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			edge_q <= '0;
			frame_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			edge_q <= edge_nx;
			frame_q <= frame_nx;
		end
	end
endmodule

// ===== rtl/core/cfb_dp.sv =====
// cfb_dp: clip derivation, fill walker, blit tracker and frame store port
// depends on cfb_pkg, cfb_ram
`timescale 1ns / 1ps
module cfb_dp import cfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_idx,
	input  logic [9:0] cfg_data,
	input  logic cmd_fire,
	input  logic [2:0] cmd_op,
	input  logic signed [CW-1:0] px,
	input  logic signed [CW-1:0] py,
	input  logic signed [CW-1:0] rw,
	input  logic signed [CW-1:0] rh,
	input  logic [CW-1:0] stride,
	input  logic [PW-1:0] color,
	input  ctl_cmd_t cmd,
	output ctl_sts_t sts,
	output logic frame_ok,
	output logic [PW-1:0] pixel_value,
	output logic inside_surface
);
	logic [9:0] surf_w_q, clip_l_q, span_x_q;
	logic [8:0] surf_h_q, clip_t_q, span_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surf_w_q <= 10'd320; surf_h_q <= 9'd200;
			clip_l_q <= '0; clip_t_q <= '0;
			span_x_q <= 10'd320; span_y_q <= 9'd200;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SURF_W: surf_w_q <= cfg_data;
				REG_SURF_H: surf_h_q <= cfg_data[8:0];
				REG_CLIP_L: clip_l_q <= cfg_data;
				REG_CLIP_T: clip_t_q <= cfg_data[8:0];
				REG_SPAN_X: span_x_q <= cfg_data;
				REG_SPAN_Y: span_y_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// clamped surface and clip window
	logic signed [SW-1:0] sw, sh, cx0, cy0, cx1, cy1;
	always_comb begin
		sw = SW'(surf_w_q);
		if (sw < 1) sw = SW'(1);
		if (sw > MaxWidth) sw = SW'(MaxWidth);
		sh = SW'(surf_h_q);
		if (sh < 1) sh = SW'(1);
		if (sh > MaxHeight) sh = SW'(MaxHeight);
		cx0 = SW'(clip_l_q);
		cy0 = SW'(clip_t_q);
		if (cx0 > sw) cx0 = sw;
		if (cy0 > sh) cy0 = sh;
		cx1 = cx0 + SW'(span_x_q);
		cy1 = cy0 + SW'(span_y_q);
		if (cx1 > sw) cx1 = sw;
		if (cy1 > sh) cy1 = sh;
	end

	logic signed [SW-1:0] ex, ey, ew, eh;
	assign ex = SW'(px);
	assign ey = SW'(py);
	assign ew = SW'(rw);
	assign eh = SW'(rh);
	assign frame_ok = (ew > 0) && (eh > 0);

	// held command fields for frame edges
	logic signed [SW-1:0] hx_q, hy_q, hw_q, hh_q;
	logic [PW-1:0] col_q;
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			hx_q <= ex; hy_q <= ey; hw_q <= ew; hh_q <= eh; col_q <= color;
		end
	end

	// rectangle for the walker: edge 0 uses live inputs, later edges the held ones
	logic signed [SW-1:0] rx, ry, rwid, rhei;
	always_comb begin
		rx = hx_q; ry = hy_q; rwid = hw_q; rhei = SW'(1);
		unique case (cmd.edge_sel)
			2'd0: begin
				rx = ex; ry = ey; rwid = ew;
				rhei = (cmd_op == OP_FRAME) ? SW'(1) : eh;
			end
			2'd1: begin ry = hy_q + hh_q - SW'(1); rhei = SW'(1); end
			2'd2: begin rwid = SW'(1); rhei = hh_q; end
			2'd3: begin rx = hx_q + hw_q - SW'(1); rwid = SW'(1); rhei = hh_q; end
			default: ;
		endcase
	end

	logic signed [SW-1:0] nx0, ny0, nx1, ny1;
	always_comb begin
		nx0 = (rx < cx0) ? cx0 : rx;
		ny0 = (ry < cy0) ? cy0 : ry;
		nx1 = rx + rwid;
		ny1 = ry + rhei;
		if (nx1 > cx1) nx1 = cx1;
		if (ny1 > cy1) ny1 = cy1;
	end

	// fill walker
	logic [XW-1:0] fx0_q, fx1_q, fx_q;
	logic [YW-1:0] fy_q, fy1_q;
	logic f_empty_q;
	logic [AW-1:0] row_base_q;
	logic [PW-1:0] fcol_q;
	logic fcol_sel;
	assign fcol_sel = cmd.edge_sel == 2'd0 && cmd_fire;

	always_ff @(posedge clk) begin
		if (cmd.load_rect) begin
			fx0_q <= XW'(nx0);
			fx_q <= XW'(nx0);
			fx1_q <= XW'(nx1);
			fy_q <= YW'(ny0);
			fy1_q <= YW'(ny1);
			f_empty_q <= (nx0 >= nx1) || (ny0 >= ny1);
			row_base_q <= AW'(ny0[YW-1:0] * sw[XW-1:0]);
			fcol_q <= fcol_sel ? color : col_q;
		end else if (cmd.step) begin
			if (fx_q + 1'b1 >= fx1_q) begin
				fx_q <= fx0_q;
				fy_q <= fy_q + 1'b1;
				row_base_q <= row_base_q + AW'(sw);
			end else begin
				fx_q <= fx_q + 1'b1;
			end
		end
	end
	assign sts.last = f_empty_q || (fx_q + 1'b1 >= fx1_q && fy_q + 1'b1 >= fy1_q);

	// blit tracker
	logic b_act_q;
	logic signed [SW-1:0] bdx_q, bdy_q, bsc_q, bsr_q, bkw_q, bkh_q;
	logic [CW:0] blen_q, brows_q, brow_q, bcol_q;
	logic signed [SW-1:0] tx, ty, tw, th, tsx, tsy, tst;
	always_comb begin
		tx = ex; ty = ey; tw = ew; th = eh; tsx = '0; tsy = '0;
		tst = SW'(stride);
		if (tx < cx0) begin tsx = cx0 - tx; tw = tw - tsx; tx = cx0; end
		if (ty < cy0) begin tsy = cy0 - ty; th = th - tsy; ty = cy0; end
		if (tx + tw > cx1) tw = cx1 - tx;
		if (ty + th > cy1) th = cy1 - ty;
		if (tw <= 0 || th <= 0) begin tw = '0; th = '0; end
		if (tst < ew) tst = ew;
		if (tst < 1) tst = SW'(1);
	end

	logic src_hit;
	logic signed [SW-1:0] bpx, bpy;
	logic signed [SW-1:0] brs, bcs;
	assign brs = SW'(brow_q);
	assign bcs = SW'(bcol_q);
	assign bpx = bdx_q + bcs - bsc_q;
	assign bpy = bdy_q + brs - bsr_q;
	assign src_hit = b_act_q && brs >= bsr_q && brs < bsr_q + bkh_q
		&& bcs >= bsc_q && bcs < bsc_q + bkw_q
		&& bpx >= 0 && bpy >= 0 && bpx < sw && bpy < sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_act_q <= 1'b0;
			brow_q <= '0; bcol_q <= '0;
		end else if (cmd_fire) begin
			if (cmd_op == OP_SRC) begin
				if (b_act_q) begin
					if (bcol_q + 1'b1 >= blen_q) begin
						bcol_q <= '0;
						brow_q <= brow_q + 1'b1;
						if (brow_q + 1'b1 >= brows_q) b_act_q <= 1'b0;
					end else begin
						bcol_q <= bcol_q + 1'b1;
					end
				end
			end else if (cmd_op == OP_BLIT) begin
				b_act_q <= eh > 0;
				brow_q <= '0; bcol_q <= '0;
			end else begin
				b_act_q <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (cmd_fire && cmd_op == OP_BLIT) begin
			bdx_q <= tx; bdy_q <= ty; bsc_q <= tsx; bsr_q <= tsy;
			bkw_q <= tw; bkh_q <= th;
			blen_q <= (CW+1)'(tst);
			brows_q <= (eh > 0) ? (CW+1)'(eh) : '0;
		end
	end

	// blit write address, registered to keep the multiply off the store port
	logic bw_s1;
	logic [AW-1:0] baddr_s1;
	logic [PW-1:0] bcol_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bw_s1 <= 1'b0;
		else bw_s1 <= cmd_fire && cmd_op == OP_SRC && src_hit;
	end
	always_ff @(posedge clk) begin
		baddr_s1 <= AW'(bpy[YW-1:0] * sw[XW-1:0]) + AW'(bpx[XW-1:0]);
		bcol_s1 <= color;
	end

	// plot pixel, also registered
	logic pw_s1;
	logic [AW-1:0] paddr_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pw_s1 <= 1'b0;
		else pw_s1 <= cmd_fire && cmd_op == OP_PIXEL
			&& ex >= cx0 && ey >= cy0 && ex < cx1 && ey < cy1;
	end
	always_ff @(posedge clk) paddr_s1 <= AW'(ey[YW-1:0] * sw[XW-1:0]) + AW'(ex[XW-1:0]);

	// clear sweep
	logic [AW:0] clr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear_step && !clr_q[AW]) clr_q <= clr_q + 1'b1;
	end
	assign sts.clear_done = clr_q[AW];

	// read address
	logic rd_in;
	logic rd_in_q;
	logic [AW-1:0] raddr;
	assign rd_in = ex >= 0 && ey >= 0 && ex < sw && ey < sh;
	assign raddr = AW'(ey[YW-1:0] * sw[XW-1:0]) + AW'(ex[XW-1:0]);
	always_ff @(posedge clk) if (cmd.read_issue) rd_in_q <= rd_in;

	// store write mux
	logic we;
	logic [AW-1:0] waddr;
	logic [PW-1:0] wdata, rdata;
	always_comb begin
		we = 1'b0; waddr = row_base_q + AW'(fx_q); wdata = fcol_q;
		if (cmd.clear_step && !clr_q[AW]) begin
			we = 1'b1; waddr = clr_q[AW-1:0]; wdata = '0;
		end else if (cmd.step && !f_empty_q) begin
			we = 1'b1;
		end else if (bw_s1) begin
			we = 1'b1; waddr = baddr_s1; wdata = bcol_s1;
		end else if (pw_s1) begin
			we = 1'b1; waddr = paddr_s1; wdata = col_q;
		end
	end

	cfb_ram #(.Width(PW), .Depth(MaxWidth * MaxHeight)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.read_take) begin
			pixel_value <= rd_in_q ? rdata : '0;
			inside_surface <= rd_in_q;
		end
	end
endmodule

// ===== rtl/core/clipped_fill_blit_engine.sv =====
// clipped_fill_blit_engine: top level of the clipped rectangle fill and blit engine
// depends on cfb_pkg, cfb_if, cfb_ctrl, cfb_dp
//
//  channel | dir | transaction
//  cmd     | in  | opcode, pos_x, pos_y, rect_w, rect_h, src_stride, color
//  res     | out | pixel_value, inside_surface (read only)
//  cfg     | in  | index, data (register write)
//
// blit start and spare opcodes finish at their accept; plot and blit source pixels
// are followed by a write gap that keeps later reads behind the store write
// fill writes one clipped pixel per cycle; an empty clip still enters fill state;
// frame, if width and height are positive, runs four clipped fills, one per edge, after its accept
// read steps through address, registered ram read, then result held until taken
// after reset a clearing pass writes zero to all 131072 store words, one per cycle
// commands stall during clear, fill, read, a pending result or a write gap
`timescale 1ns / 1ps
module clipped_fill_blit_engine import cfb_pkg::*; (
	input logic clk,
	input logic arst_n,
	cfb_cmd_if.sink cmd,
	cfb_res_if.source res,
	cfb_cfg_if.sink cfg
);
	ctl_cmd_t ctl;
	ctl_sts_t sts;
	logic busy, frame_ok, res_pend, cmd_fire;
	// one-cycle gap after plot or blit writes keeps reads ordered behind them
	logic wr_pend_q;

	assign cmd.ready = !busy && !wr_pend_q;
	assign cmd_fire = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;
	assign res_pend = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wr_pend_q <= 1'b0;
		else wr_pend_q <= cmd_fire && (cmd.opcode == OP_PIXEL || cmd.opcode == OP_SRC);
	end

	cfb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cmd_fire(cmd_fire), .cmd_op(cmd.opcode),
		.frame_ok(frame_ok), .res_busy(res_pend), .res_taken(res.ready),
		.sts(sts), .cmd(ctl), .busy(busy), .res_valid(res.valid)
	);

	cfb_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg.valid), .cfg_idx(cfg.index),
		.cfg_data(cfg.data), .cmd_fire(cmd_fire), .cmd_op(cmd.opcode),
		.px(cmd.pos_x), .py(cmd.pos_y), .rw(cmd.rect_w), .rh(cmd.rect_h),
		.stride(cmd.src_stride), .color(cmd.color), .cmd(ctl), .sts(sts),
		.frame_ok(frame_ok), .pixel_value(res.pixel_value),
		.inside_surface(res.inside_surface)
	);

	// no command is taken while a result waits
	a_no_cmd_with_res: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !cmd.ready) else $error("command taken during result");
	// a read passes through ST_READ and then produces a result in ST_RESULT
	a_read_res: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && cmd.opcode == OP_READ) |-> ##2 res.valid)
		else $error("read gave no result");
	// the store is never written by fill and clear together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.step && ctl.clear_step)) else $error("fill during clear");
endmodule
